// File: hdl/tbss_pkg.sv
// ---------------------------------------------------------------------------
// tbss_pkg: time base sync scheduler shared definitions
// Field widths, opcodes, register indexes, pipeline records and the
// reciprocal steps of the millisecond-to-second divider.
// ---------------------------------------------------------------------------
`default_nettype none

package tbss_pkg;

   localparam int OpWidth    = 3;
   localparam int MonoWidth  = 48;
   localparam int UtcWidth   = 32;
   localparam int CfgWidth   = 32;
   localparam int CsrIdWidth = 1;

   // divide by 1000 as a shift by 3 then a divide by 125; the 45-bit value
   // is split into a 24-bit upper part and a 21-bit lower part
   localparam int DivSteps       = 3;
   localparam int PreShift       = 3;
   localparam int HiWidth        = 24;
   localparam int LoWidth        = 21;
   localparam int RemWidth       = 7;
   localparam int FoldWidth      = RemWidth + LoWidth;
   localparam int HiQuoWidth     = 18;
   localparam int HiRecipWidth   = 25;
   localparam int FoldRecipWidth = 29;
   localparam int HiProdWidth    = HiWidth + HiRecipWidth;
   localparam int FoldProdWidth  = FoldWidth + FoldRecipWidth;
   localparam int HiShift        = 31;
   localparam int FoldShift      = 35;

   localparam logic [RemWidth-1:0]       DivOdd    = 7'd125;
   // ceil(2^31 / 125), exact for any 24-bit value
   localparam logic [HiRecipWidth-1:0]   HiRecip   = 25'd17179870;
   // ceil(2^35 / 125), exact for any 28-bit value
   localparam logic [FoldRecipWidth-1:0] FoldRecip = 29'd274877907;

   localparam logic [CfgWidth-1:0] ResyncReset = 32'd3600000;
   localparam logic [CfgWidth-1:0] RetryReset  = 32'd30000;

   localparam logic [CsrIdWidth-1:0] CsrResync = 1'b0;
   localparam logic [CsrIdWidth-1:0] CsrRetry  = 1'b1;

   typedef enum logic [OpWidth-1:0] {
      OP_QUERY    = 3'd0,
      OP_SET_RTC  = 3'd1,
      OP_SET_NTP  = 3'd2,
      OP_NET_UP   = 3'd3,
      OP_NET_DOWN = 3'd4,
      OP_MARK     = 3'd5
   } op_type;

   typedef struct packed {
      logic [CfgWidth-1:0] resync_period;
      logic [CfgWidth-1:0] retry_period;
   } cfg_type;

   // work handed from the state update to the divider
   typedef struct packed {
      logic [MonoWidth-1:0] dividend;
      logic [UtcWidth-1:0]  addend;
      logic                 time_valid;
      logic                 time_source;
      logic                 sync_due;
   } work_type;

   typedef struct packed {
      logic [MonoWidth-1:0] num;
      logic [UtcWidth-1:0]  quo;
      logic [UtcWidth-1:0]  addend;
      logic                 time_valid;
      logic                 time_source;
      logic                 sync_due;
   } div_stage_type;

   typedef struct packed {
      logic [UtcWidth-1:0] now_utc;
      logic                time_valid;
      logic                time_source;
      logic                sync_due;
   } result_type;

   // quotient of the upper part by 125
   function automatic div_stage_type div_high(div_stage_type s);
      div_stage_type          r;
      logic [HiProdWidth-1:0] prod;
      r     = s;
      prod  = {{HiRecipWidth{1'b0}}, s.num[MonoWidth-1 -: HiWidth]} *
              {{HiWidth{1'b0}}, HiRecip};
      r.quo = {{(UtcWidth-HiQuoWidth){1'b0}}, prod[HiShift +: HiQuoWidth]};
      return r;
   endfunction

   // fold the upper remainder on top of the lower part
   function automatic div_stage_type div_fold(div_stage_type s);
      div_stage_type      r;
      logic [HiWidth-1:0] back;
      logic [HiWidth-1:0] rest;
      r     = s;
      back  = {{(HiWidth-HiQuoWidth){1'b0}}, s.quo[HiQuoWidth-1:0]} *
              {{(HiWidth-RemWidth){1'b0}}, DivOdd};
      rest  = s.num[MonoWidth-1 -: HiWidth] - back;
      r.num = {{(MonoWidth-FoldWidth){1'b0}}, rest[RemWidth-1:0],
               s.num[PreShift +: LoWidth]};
      return r;
   endfunction

   // quotient of the folded value by 125, joined below the upper quotient
   function automatic div_stage_type div_low(div_stage_type s);
      div_stage_type            r;
      logic [FoldProdWidth-1:0] prod;
      r     = s;
      prod  = {{FoldRecipWidth{1'b0}}, s.num[FoldWidth-1:0]} *
              {{FoldWidth{1'b0}}, FoldRecip};
      r.quo = {s.quo[UtcWidth-LoWidth-1:0], prod[FoldShift +: LoWidth]};
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/time_base_sync_scheduler_core.sv
// ---------------------------------------------------------------------------
// time_base_sync_scheduler_core: UTC time base and NTP sync scheduler
//
// Each request on the req_ channel is one event (opcode in req_tuser, the
// monotonic millisecond count and a UTC value in req_tdata). The event is
// applied to the time base and sync timers in the cycle it is accepted, and
// one response per request leaves on the rsp_ channel in request order: the
// current UTC, the base-valid and source flags and the sync-due flag.
// Throughput is one request per cycle while the receiver takes responses. A
// response passes through the input register, three divide stages (upper
// quotient by reciprocal multiply, remainder fold, lower quotient) and the
// result register where the base UTC is added.
// When the receiver stalls, the response holds in the result register and
// requests are still taken until all five registers hold one; req_tready
// then drops. The csr_ port writes the resync (index 0) and retry (index 1)
// intervals and may be written only while the block is idle.
// Synchronous reset clears the time base, flags and pipeline valids and
// restores the intervals to 3600000 ms and 30000 ms.
// ---------------------------------------------------------------------------
`default_nettype none

module time_base_sync_scheduler_core
   import tbss_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [79:0]            req_tdata,   // mono_ms[47:0], utc_seconds[79:48]
   input  wire  [OpWidth-1:0]     req_tuser,   // opcode[2:0]
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [39:0]            rsp_tdata,   // now_utc[31:0], time_valid[32],
                                               // time_source[33], sync_due[34]
   input  wire                    csr_we,
   input  wire  [CsrIdWidth-1:0]  csr_index,
   input  wire  [CfgWidth-1:0]    csr_wdata
);

   logic       accept;
   work_type   work;
   result_type result;

   assign accept = req_tvalid && req_tready;

   tbss_state u_state (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .opcode      (req_tuser),
      .mono_ms     (req_tdata[MonoWidth-1:0]),
      .utc_seconds (req_tdata[MonoWidth+UtcWidth-1:MonoWidth]),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .work        (work)
   );

   tbss_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_work    (work),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {5'd0, result.sync_due, result.time_source, result.time_valid,
                       result.now_utc};

endmodule

`default_nettype wire

// File: hdl/tbss_state.sv
// ---------------------------------------------------------------------------
// tbss_state: event decode and time base state
// Applies each accepted request to the base and sync timers, holds the
// interval registers and evaluates the sync-due flag at the event time.
// ---------------------------------------------------------------------------
`default_nettype none

module tbss_state
   import tbss_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  wire  [OpWidth-1:0]     opcode,
   input  wire  [MonoWidth-1:0]   mono_ms,
   input  wire  [UtcWidth-1:0]    utc_seconds,
   input  wire                    csr_we,
   input  wire  [CsrIdWidth-1:0]  csr_index,
   input  wire  [CfgWidth-1:0]    csr_wdata,
   output work_type               work
);

   cfg_type              cfg_ff;
   logic                 base_valid_ff,   base_valid_in;
   logic                 base_source_ff,  base_source_in;
   logic [UtcWidth-1:0]  base_utc_ff,     base_utc_in;
   logic [MonoWidth-1:0] base_mono_ff,    base_mono_in;
   logic [UtcWidth-1:0]  last_ntp_ff,     last_ntp_in;
   logic [MonoWidth-1:0] last_sync_ff,    last_sync_in;
   logic [MonoWidth-1:0] last_attempt_ff, last_attempt_in;
   logic                 synced_ff,       synced_in;
   logic                 armed_ff,        armed_in;
   logic                 net_up_ff,       net_up_in;
   logic                 has_attempt_ff,  has_attempt_in;

   logic [MonoWidth-1:0] since_sync;
   logic [MonoWidth-1:0] since_attempt;
   logic                 resync_due;
   logic                 retry_due;

   always_comb begin
      base_valid_in   = base_valid_ff;
      base_source_in  = base_source_ff;
      base_utc_in     = base_utc_ff;
      base_mono_in    = base_mono_ff;
      last_ntp_in     = last_ntp_ff;
      last_sync_in    = last_sync_ff;
      last_attempt_in = last_attempt_ff;
      synced_in       = synced_ff;
      armed_in        = armed_ff;
      net_up_in       = net_up_ff;
      has_attempt_in  = has_attempt_ff;
      if (accept) begin
         unique case (opcode)
            OP_SET_RTC: begin
               base_valid_in  = 1'b1;
               base_source_in = 1'b0;
               base_utc_in    = utc_seconds;
               base_mono_in   = mono_ms;
            end
            OP_SET_NTP: begin
               base_valid_in  = 1'b1;
               base_source_in = 1'b1;
               base_utc_in    = utc_seconds;
               base_mono_in   = mono_ms;
               last_ntp_in    = utc_seconds;
               last_sync_in   = mono_ms;
               synced_in      = 1'b1;
               armed_in       = 1'b0;
            end
            OP_NET_UP: begin
               net_up_in      = 1'b1;
               armed_in       = 1'b1;
               synced_in      = 1'b0;
               has_attempt_in = 1'b0;
            end
            OP_NET_DOWN: begin
               net_up_in = 1'b0;
            end
            OP_MARK: begin
               last_attempt_in = mono_ms;
               has_attempt_in  = 1'b1;
            end
            default: begin
               // query and unused codes leave the state alone
            end
         endcase
      end
   end

   // timers are judged against the state after this event
   always_comb begin
      since_sync    = mono_ms - last_sync_in;
      since_attempt = mono_ms - last_attempt_in;
      resync_due    = (last_ntp_in != '0) &&
                      (since_sync >= {16'd0, cfg_ff.resync_period});
      retry_due     = !synced_in && has_attempt_in &&
                      (since_attempt >= {16'd0, cfg_ff.retry_period});

      work.sync_due    = net_up_in && ((armed_in && !has_attempt_in) ||
                                       resync_due || retry_due);
      work.time_valid  = base_valid_in;
      work.time_source = base_valid_in && base_source_in;
      if (base_valid_in) begin
         work.dividend = mono_ms - base_mono_in;
         work.addend   = base_utc_in;
      end else begin
         work.dividend = mono_ms;
         work.addend   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.resync_period <= ResyncReset;
         cfg_ff.retry_period  <= RetryReset;
         base_valid_ff   <= 1'b0;
         base_source_ff  <= 1'b0;
         base_utc_ff     <= '0;
         base_mono_ff    <= '0;
         last_ntp_ff     <= '0;
         last_sync_ff    <= '0;
         last_attempt_ff <= '0;
         synced_ff       <= 1'b0;
         armed_ff        <= 1'b0;
         net_up_ff       <= 1'b0;
         has_attempt_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CsrResync: cfg_ff.resync_period <= csr_wdata;
               CsrRetry:  cfg_ff.retry_period  <= csr_wdata;
               default:   cfg_ff <= cfg_ff;
            endcase
         end
         base_valid_ff   <= base_valid_in;
         base_source_ff  <= base_source_in;
         base_utc_ff     <= base_utc_in;
         base_mono_ff    <= base_mono_in;
         last_ntp_ff     <= last_ntp_in;
         last_sync_ff    <= last_sync_in;
         last_attempt_ff <= last_attempt_in;
         synced_ff       <= synced_in;
         armed_ff        <= armed_in;
         net_up_ff       <= net_up_in;
         has_attempt_ff  <= has_attempt_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/tbss_div.sv
// ---------------------------------------------------------------------------
// tbss_div: pipelined divide by 1000 and result register
// Input register, three reciprocal-multiply stages (upper quotient, remainder
// fold, lower quotient), then the base add into the result register.
// Each stage advances when the next has room.
// ---------------------------------------------------------------------------
`default_nettype none

module tbss_div
   import tbss_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           in_valid,
   output logic          in_ready,
   input  wire work_type in_work,
   output logic          out_valid,
   input  wire           out_ready,
   output result_type    out_result
);

   div_stage_type     stage_ff [0:DivSteps];
   div_stage_type     stage_in [0:DivSteps];
   logic [DivSteps:0] valid_ff, valid_in;
   logic [DivSteps:0] stage_ready;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ready;
   result_type        rsp_ff;

   always_comb begin
      rsp_ready             = !rsp_valid_ff || out_ready;
      stage_ready[DivSteps] = !valid_ff[DivSteps] || rsp_ready;
      for (int k = DivSteps - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      in_ready = stage_ready[0];
   end

   always_comb begin
      stage_in[0].num         = in_work.dividend;
      stage_in[0].quo         = '0;
      stage_in[0].addend      = in_work.addend;
      stage_in[0].time_valid  = in_work.time_valid;
      stage_in[0].time_source = in_work.time_source;
      stage_in[0].sync_due    = in_work.sync_due;
      valid_in[0] = stage_ready[0] ? in_valid : valid_ff[0];
      stage_in[1] = div_high(stage_ff[0]);
      stage_in[2] = div_fold(stage_ff[1]);
      stage_in[3] = div_low(stage_ff[2]);
      for (int k = 1; k <= DivSteps; k++) begin
         valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
      rsp_valid_in = rsp_ready ? valid_ff[DivSteps] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DivSteps; k++) begin
         if (stage_ready[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
      if (rsp_ready) begin
         rsp_ff.now_utc     <= stage_ff[DivSteps].addend + stage_ff[DivSteps].quo;
         rsp_ff.time_valid  <= stage_ff[DivSteps].time_valid;
         rsp_ff.time_source <= stage_ff[DivSteps].time_source;
         rsp_ff.sync_due    <= stage_ff[DivSteps].sync_due;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_result = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/tbss_checker.sv
// ---------------------------------------------------------------------------
// tbss_checker: port-level checks for the sync scheduler
// Watches the top-level channels only and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tbss_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_tready,
   input wire                    rsp_tvalid,
   input wire                    rsp_tready,
   input wire  [39:0]            rsp_tdata
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response dropped or changed");

   // the source flag only reads as ntp once a base is set
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[33] || rsp_tdata[32])
      else $error("time source set without a valid base");

   // pad bits of the response stay clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:35] == 5'd0)
      else $error("response pad bits set");

   // no response straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // an empty pipeline always takes a request
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_tready)
      else $error("request not taken after reset");

endmodule

bind time_base_sync_scheduler_core tbss_checker u_checker (.*);

`default_nettype wire

// File: dv/time_base_sync_scheduler_core_tb.sv
// ---------------------------------------------------------------------------
// time_base_sync_scheduler_core_tb: self-checking bench for the time base core
// Walks a table of directed events (reset state, opcode extremes, UTC wrap,
// timer edges), then random event streams under several interval settings.
// A local model of the time base predicts every response; responses are
// compared field by field in request order while both sides idle at random.
// ---------------------------------------------------------------------------
`default_nettype none

module time_base_sync_scheduler_core_tb;
   import tbss_pkg::*;

   localparam logic [OpWidth-1:0] OpUnused6 = 3'd6;
   localparam logic [OpWidth-1:0] OpUnused7 = 3'd7;
   localparam int ItemsPerPhase = 90;
   localparam int LongHoldAt    = 120;
   localparam int LongHoldCycles = 80;

   typedef struct {
      logic [OpWidth-1:0]   op;
      logic [MonoWidth-1:0] mono;
      logic [UtcWidth-1:0]  utc;
      bit                   fixed;
      result_type           want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [79:0]           req_tdata = '0;
   logic [OpWidth-1:0]    req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CsrIdWidth-1:0] csr_index = '0;
   logic [CfgWidth-1:0]   csr_wdata = '0;

   // local copy of the time base and sync timers
   bit                   have_base;
   bit                   base_is_ntp;
   logic [UtcWidth-1:0]  base_utc_s = '0;
   logic [MonoWidth-1:0] base_mono_ms = '0;
   logic [UtcWidth-1:0]  ntp_utc_s = '0;
   logic [MonoWidth-1:0] ntp_mono_ms = '0;
   logic [MonoWidth-1:0] attempt_mono_ms = '0;
   bit                   synced_after_up;
   bit                   first_try_armed;
   bit                   link_up;
   bit                   attempt_seen;
   logic [CfgWidth-1:0]  resync_ms = ResyncReset;
   logic [CfgWidth-1:0]  retry_ms  = RetryReset;

   result_type           expected_readings[$];
   int unsigned          readings_seen = 0;
   int unsigned          mismatch_count = 0;
   bit                   no_gaps = 1'b0;
   logic [MonoWidth-1:0] mono_now = '0;

   stim_row_type directed_rows [22] = '{
      '{OP_QUERY,    48'd0,              32'd0,          1'b1, '{32'd0, 1'b0, 1'b0, 1'b0}},
      '{OP_QUERY,    48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,  1'b0, '0},
      '{OpUnused6,   48'd5000,           32'hFFFF_FFFF,  1'b1, '{32'd5, 1'b0, 1'b0, 1'b0}},
      '{OpUnused7,   48'd12345,          32'd7,          1'b1, '{32'd12, 1'b0, 1'b0, 1'b0}},
      '{OP_NET_UP,   48'd1000,           32'd0,          1'b1, '{32'd1, 1'b0, 1'b0, 1'b1}},
      '{OP_MARK,     48'd2000,           32'd0,          1'b1, '{32'd2, 1'b0, 1'b0, 1'b0}},
      '{OP_QUERY,    48'd31999,          32'd0,          1'b1, '{32'd31, 1'b0, 1'b0, 1'b0}},
      '{OP_QUERY,    48'd32000,          32'd0,          1'b1, '{32'd32, 1'b0, 1'b0, 1'b1}},
      '{OP_SET_RTC,  48'd40000,          32'hFFFF_FFFF,  1'b1,
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1}},
      '{OP_QUERY,    48'd41000,          32'd0,          1'b1, '{32'd0, 1'b1, 1'b0, 1'b1}},
      '{OP_SET_NTP,  48'd50000,          32'd0,          1'b1, '{32'd0, 1'b1, 1'b1, 1'b0}},
      '{OP_QUERY,    48'd3650000,        32'd0,          1'b1, '{32'd3600, 1'b1, 1'b1, 1'b0}},
      '{OP_SET_NTP,  48'd4000000,        32'd100,        1'b1, '{32'd100, 1'b1, 1'b1, 1'b0}},
      '{OP_QUERY,    48'd7599999,        32'd0,          1'b1, '{32'd3699, 1'b1, 1'b1, 1'b0}},
      '{OP_QUERY,    48'd7600000,        32'd0,          1'b1, '{32'd3700, 1'b1, 1'b1, 1'b1}},
      '{OP_NET_DOWN, 48'd7600000,        32'd0,          1'b1, '{32'd3700, 1'b1, 1'b1, 1'b0}},
      '{OP_QUERY,    48'd0,              32'd0,          1'b0, '0},
      '{OP_NET_UP,   48'd1,              32'hFFFF_FFFF,  1'b0, '0},
      '{OP_MARK,     48'hFFFF_FFFF_FFFF, 32'd0,          1'b0, '0},
      '{OP_SET_RTC,  48'h5555_5555_5555, 32'hAAAA_AAAA,  1'b0, '0},
      '{OP_SET_NTP,  48'hAAAA_AAAA_AAAA, 32'h5555_5555,  1'b0, '0},
      '{OpUnused7,   48'hAAAA_AAAA_B000, 32'h1234_5678,  1'b0, '0}
   };

   time_base_sync_scheduler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // apply one event to the local time base, return the reading it gives
   function automatic result_type advance_time_base(logic [OpWidth-1:0] op,
                                                    logic [MonoWidth-1:0] mono,
                                                    logic [UtcWidth-1:0] utc);
      result_type           r;
      logic [MonoWidth-1:0] since_base;
      logic [MonoWidth-1:0] since_ntp;
      logic [MonoWidth-1:0] since_attempt;
      case (op)
         OP_SET_RTC: begin
            have_base    = 1'b1;
            base_is_ntp  = 1'b0;
            base_utc_s   = utc;
            base_mono_ms = mono;
         end
         OP_SET_NTP: begin
            have_base       = 1'b1;
            base_is_ntp     = 1'b1;
            base_utc_s      = utc;
            base_mono_ms    = mono;
            ntp_utc_s       = utc;
            ntp_mono_ms     = mono;
            synced_after_up = 1'b1;
            first_try_armed = 1'b0;
         end
         OP_NET_UP: begin
            link_up         = 1'b1;
            first_try_armed = 1'b1;
            synced_after_up = 1'b0;
            attempt_seen    = 1'b0;
         end
         OP_NET_DOWN: link_up = 1'b0;
         OP_MARK: begin
            attempt_mono_ms = mono;
            attempt_seen    = 1'b1;
         end
         default: ;
      endcase
      since_base    = mono - base_mono_ms;
      since_ntp     = mono - ntp_mono_ms;
      since_attempt = mono - attempt_mono_ms;
      if (have_base) begin
         r.now_utc = base_utc_s + UtcWidth'(since_base / 48'd1000);
      end else begin
         r.now_utc = UtcWidth'(mono / 48'd1000);
      end
      r.time_valid  = have_base;
      r.time_source = have_base && base_is_ntp;
      r.sync_due    = link_up &&
                      ((first_try_armed && !attempt_seen) ||
                       (ntp_utc_s != '0 && since_ntp >= MonoWidth'(resync_ms)) ||
                       (!synced_after_up && attempt_seen &&
                        since_attempt >= MonoWidth'(retry_ms)));
      return r;
   endfunction

   task automatic flag_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic send_event(logic [OpWidth-1:0] op, logic [MonoWidth-1:0] mono,
                             logic [UtcWidth-1:0] utc, bit fixed, result_type fixed_res);
      int unsigned gap;
      result_type  predicted;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {utc, mono};
      do @(posedge clock); while (!req_tready);
      predicted = advance_time_base(op, mono, utc);
      expected_readings.push_back(fixed ? fixed_res : predicted);
   endtask

   task automatic drain_readings();
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic program_intervals(logic [CfgWidth-1:0] resync, logic [CfgWidth-1:0] retry);
      csr_we    <= 1'b1;
      csr_index <= CsrResync;
      csr_wdata <= resync;
      @(posedge clock);
      csr_index <= CsrRetry;
      csr_wdata <= retry;
      @(posedge clock);
      csr_we    <= 1'b0;
      resync_ms = resync;
      retry_ms  = retry;
   endtask

   task automatic run_phase(int phase);
      logic [CfgWidth-1:0] resync;
      logic [CfgWidth-1:0] retry;
      logic [OpWidth-1:0]  op;
      logic [UtcWidth-1:0] utc;
      int unsigned         step_max;
      int unsigned         pick;
      req_tvalid <= 1'b0;
      drain_readings();
      case (phase)
         0: begin
            resync = '0;
            retry  = '0;
         end
         1: begin
            resync   = '1;
            retry    = '1;
            // start close to the 48-bit wrap
            mono_now = 48'hFFFF_F000_0000 + MonoWidth'($urandom);
         end
         2: begin
            resync = $urandom_range(1, 20000);
            retry  = $urandom_range(1, 20000);
         end
         3: begin
            resync = $urandom;
            retry  = $urandom;
         end
         default: begin
            resync = ResyncReset;
            retry  = RetryReset;
         end
      endcase
      no_gaps = (phase == 2);
      program_intervals(resync, retry);
      step_max = (resync > retry ? resync : retry) / 8 + 1000;
      send_event(OP_NET_UP, mono_now, $urandom, 1'b0, '0);
      repeat (ItemsPerPhase - 1) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            mono_now = MonoWidth'({$urandom, $urandom});
         end else if (pick < 6) begin
            mono_now = mono_now - MonoWidth'($urandom_range(0, 5000));
         end else begin
            mono_now = mono_now + MonoWidth'($urandom_range(0, step_max));
         end
         pick = $urandom_range(0, 99);
         if (pick < 42)      op = OP_QUERY;
         else if (pick < 58) op = OP_MARK;
         else if (pick < 66) op = OP_NET_UP;
         else if (pick < 73) op = OP_NET_DOWN;
         else if (pick < 83) op = OP_SET_NTP;
         else if (pick < 91) op = OP_SET_RTC;
         else if (pick < 96) op = OpUnused6;
         else                op = OpUnused7;
         pick = $urandom_range(0, 9);
         if (pick == 0)      utc = '0;
         else if (pick == 1) utc = '1;
         else                utc = $urandom;
         send_event(op, mono_now, utc, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         send_event(directed_rows[i].op, directed_rows[i].mono, directed_rows[i].utc,
                    directed_rows[i].fixed, directed_rows[i].want);
      end
      for (int p = 0; p < 5; p++) begin
         run_phase(p);
      end
      req_tvalid <= 1'b0;
      drain_readings();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("time_base_sync_scheduler_core_tb: PASS");
      end else begin
         $display("time_base_sync_scheduler_core_tb: FAIL");
      end
      $finish;
   end

   initial begin : response_sink
      int unsigned stall;
      result_type  got;
      result_type  want;
      while (reset) @(posedge clock);
      forever begin
         // hold off once for long enough to fill the divider and stall requests
         if (readings_seen == LongHoldAt) begin
            stall = LongHoldCycles;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         readings_seen++;
         got.now_utc     = rsp_tdata[31:0];
         got.time_valid  = rsp_tdata[32];
         got.time_source = rsp_tdata[33];
         got.sync_due    = rsp_tdata[34];
         if (expected_readings.size() == 0) begin
            flag_mismatch($sformatf("response with no request outstanding, now_utc %0d",
                                    got.now_utc));
         end else begin
            want = expected_readings.pop_front();
            if (got.now_utc !== want.now_utc) begin
               flag_mismatch($sformatf("response %0d now_utc %0d, want %0d",
                                       readings_seen, got.now_utc, want.now_utc));
            end
            if (got.time_valid !== want.time_valid) begin
               flag_mismatch($sformatf("response %0d time_valid %b, want %b",
                                       readings_seen, got.time_valid, want.time_valid));
            end
            if (got.time_source !== want.time_source) begin
               flag_mismatch($sformatf("response %0d time_source %b, want %b",
                                       readings_seen, got.time_source, want.time_source));
            end
            if (got.sync_due !== want.sync_due) begin
               flag_mismatch($sformatf("response %0d sync_due %b, want %b",
                                       readings_seen, got.sync_due, want.sync_due));
            end
         end
      end
   end

   initial begin : watchdog
      #2000000;
      $display("time_base_sync_scheduler_core_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
